// ----- rtl/multiview_pixel_source_mapper_unit_defines.svh -----
// Assertion macros shared by the mapper RTL.
`ifndef MULTIVIEW_PIXEL_SOURCE_MAPPER_UNIT_DEFINES_SVH
`define MULTIVIEW_PIXEL_SOURCE_MAPPER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define MVPSM_ASSERT_HOLD(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("mvpsm: check failed");
`define MVPSM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mvpsm: implication failed");
`define MVPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mvpsm: next-cycle check failed");
`else
`define MVPSM_ASSERT_HOLD(label, clk, rst_n, cond)
`define MVPSM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MVPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/mvpsm_pkg.sv -----
package mvpsm_pkg;

    localparam int MAX_TRACKS  = 4;
    localparam int COEF_SLOTS  = 4;
    localparam int COEF_KINDS  = 6;

    localparam int COORD_W = 18;
    localparam int COEF_W  = 32;
    localparam int SLOT_W  = 2;
    localparam int CNT_W   = 3;
    localparam int KIND_W  = 3;
    localparam int LOC_W   = 17;
    localparam int SPLIT_W = 17;
    localparam int LO_W    = 16;
    localparam int DIFF_W  = COEF_W + 1;
    localparam int HI_W    = DIFF_W - LO_W;
    localparam int PROD_W  = HI_W + COEF_W;
    localparam int Q_W     = PROD_W + 1;
    localparam int T_W     = Q_W + 1;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam int UNIT       = 65536;
    localparam int U_CLAMP_HI = 65535;
    localparam int SPLIT_LO   = 7;
    localparam int SPLIT_HI   = 65529;

    localparam logic MODE_MAP   = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [1:0] LAYOUT_SBS   = 2'd0;
    localparam logic [1:0] LAYOUT_SPLIT = 2'd1;

    localparam logic [KIND_W-1:0] KIND_OFF_X  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INV_X  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VIEW_X = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OFF_Y  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INV_Y  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_VIEW_Y = 3'd5;

    localparam logic [2:0] REG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_LAYOUT  = 3'd1;
    localparam logic [2:0] REG_TRACKS  = 3'd2;
    localparam logic [2:0] REG_SPLIT   = 3'd3;
    localparam logic [2:0] REG_ORDER   = 3'd4;
    localparam logic [2:0] REG_PRESENT = 3'd5;

    typedef struct packed {
        logic               enable;
        logic [1:0]         layout_mode;
        logic [CNT_W-1:0]   active_tracks;
        logic [SPLIT_W-1:0] split_position;
        logic [7:0]         slot_order;
        logic [3:0]         present_mask;
    } t_cfg;

    typedef struct packed {
        logic [COEF_W-1:0] off_x;
        logic [COEF_W-1:0] inv_x;
        logic [COEF_W-1:0] view_x;
        logic [COEF_W-1:0] off_y;
        logic [COEF_W-1:0] inv_y;
        logic [COEF_W-1:0] view_y;
    } t_coef_set;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

// ----- rtl/mvpsm_front.sv -----
module mvpsm_front (
    input  mvpsm_pkg::t_cfg                     i_cfg,
    input  logic signed [mvpsm_pkg::COORD_W-1:0] i_coord_u,
    output logic [mvpsm_pkg::SLOT_W-1:0]         o_sslot,
    output logic signed [mvpsm_pkg::COORD_W-1:0] o_lu,
    output logic                                 o_drop
);
    import mvpsm_pkg::*;

    localparam int SCALE_W = LO_W + CNT_W;

    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   disp_count;
    logic [LO_W-1:0]    cu;
    logic [SCALE_W-1:0] scaled;
    logic [SPLIT_W-1:0] split;
    logic [CNT_W-1:0]   dslot;
    logic [1:0]         raw_slot;
    logic [7:0]         order_shift;

    always_comb begin
        count = i_cfg.active_tracks;
        if (count == '0) begin
            count = CNT_W'(1);
        end
        if (int'(count) > MAX_TRACKS) begin
            count = CNT_W'(MAX_TRACKS);
        end
        disp_count = (i_cfg.layout_mode == LAYOUT_SPLIT && count > CNT_W'(1))
                   ? CNT_W'(2) : count;

        if (i_coord_u[COORD_W-1]) begin
            cu = '0;
        end else if (i_coord_u > COORD_W'(U_CLAMP_HI)) begin
            cu = LO_W'(U_CLAMP_HI);
        end else begin
            cu = i_coord_u[LO_W-1:0];
        end
        scaled = SCALE_W'(cu) * SCALE_W'(disp_count);

        split = i_cfg.split_position;
        if (split < SPLIT_W'(SPLIT_LO)) begin
            split = SPLIT_W'(SPLIT_LO);
        end
        if (split > SPLIT_W'(SPLIT_HI)) begin
            split = SPLIT_W'(SPLIT_HI);
        end

        dslot = '0;
        o_lu  = i_coord_u;
        if (i_cfg.layout_mode == LAYOUT_SBS && disp_count > CNT_W'(1)) begin
            dslot = scaled[SCALE_W-1:LO_W];
            o_lu  = $signed({{(COORD_W-LO_W){1'b0}}, scaled[LO_W-1:0]});
        end else if (i_cfg.layout_mode == LAYOUT_SPLIT && disp_count > CNT_W'(1)) begin
            dslot = ($signed({i_coord_u[COORD_W-1], i_coord_u}) <
                     $signed({2'b00, split})) ? CNT_W'(0) : CNT_W'(1);
        end

        order_shift = i_cfg.slot_order >> {dslot[1:0], 1'b0};
        raw_slot    = order_shift[1:0];
        o_sslot     = raw_slot;
        if (int'(raw_slot) > MAX_TRACKS - 1) begin
            o_sslot = SLOT_W'(MAX_TRACKS - 1);
        end
        o_drop = !i_cfg.enable || !i_cfg.present_mask[o_sslot];
    end

endmodule

// ----- rtl/mvpsm_coef.sv -----
module mvpsm_coef (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_we,
    input  logic [mvpsm_pkg::SLOT_W-1:0]      i_wslot,
    input  logic [mvpsm_pkg::KIND_W-1:0]      i_wkind,
    input  logic [mvpsm_pkg::COEF_W-1:0]      i_wdata,
    input  logic [mvpsm_pkg::SLOT_W-1:0]      i_rslot,
    output mvpsm_pkg::t_coef_set              o_coef
);
    import mvpsm_pkg::*;

    logic [COEF_W-1:0] r_tab [COEF_KINDS][COEF_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < COEF_KINDS; k++) begin
                for (int s = 0; s < COEF_SLOTS; s++) begin
                    r_tab[k][s] <= '0;
                end
            end
        end else if (i_we && i_wkind < KIND_W'(COEF_KINDS)) begin
            r_tab[i_wkind][i_wslot] <= i_wdata;
        end
    end

    always_comb begin
        o_coef.off_x  = r_tab[KIND_OFF_X][i_rslot];
        o_coef.inv_x  = r_tab[KIND_INV_X][i_rslot];
        o_coef.view_x = r_tab[KIND_VIEW_X][i_rslot];
        o_coef.off_y  = r_tab[KIND_OFF_Y][i_rslot];
        o_coef.inv_y  = r_tab[KIND_INV_Y][i_rslot];
        o_coef.view_y = r_tab[KIND_VIEW_Y][i_rslot];
    end

endmodule

// ----- rtl/mvpsm_lane.sv -----
module mvpsm_lane (
    input  logic                                 i_clk,
    input  mvpsm_pkg::t_pipe_en                  i_en,
    input  logic signed [mvpsm_pkg::COORD_W-1:0] i_coord,
    input  logic signed [mvpsm_pkg::COEF_W-1:0]  i_off,
    input  logic signed [mvpsm_pkg::COEF_W-1:0]  i_inv,
    input  logic signed [mvpsm_pkg::COEF_W-1:0]  i_view,
    output logic                                 o_ok,
    output logic [mvpsm_pkg::LOC_W-1:0]          o_local
);
    import mvpsm_pkg::*;

    localparam logic [T_W-1:0] T_BOUND = T_W'(UNIT);

    logic signed [DIFF_W-1:0] r_diff;
    logic signed [COEF_W-1:0] r_inv2;
    logic signed [COEF_W-1:0] r_view2;
    logic signed [PROD_W-1:0] r_plo;
    logic signed [PROD_W-1:0] r_phi;
    logic signed [COEF_W-1:0] r_view3;
    logic signed [Q_W-1:0]    r_q;
    logic signed [COEF_W-1:0] r_view4;

    logic signed [HI_W-1:0]   d_lo;
    logic signed [HI_W-1:0]   d_hi;
    logic signed [T_W-1:0]    t;

    assign d_lo = $signed({1'b0, r_diff[LO_W-1:0]});
    assign d_hi = $signed(r_diff[DIFF_W-1:LO_W]);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_diff  <= DIFF_W'(i_coord) - DIFF_W'(i_off);
            r_inv2  <= i_inv;
            r_view2 <= i_view;
        end
        if (i_en.s3) begin
            r_plo   <= d_lo * r_inv2;
            r_phi   <= d_hi * r_inv2;
            r_view3 <= r_view2;
        end
        if (i_en.s4) begin
            r_q     <= Q_W'(r_phi) + Q_W'(r_plo >>> LO_W);
            r_view4 <= r_view3;
        end
    end

    always_comb begin
        t       = T_W'(r_q) - T_W'(r_view4);
        o_ok    = !t[T_W-1] && ($unsigned(t) <= T_BOUND);
        o_local = t[LOC_W-1:0];
    end

endmodule

// ----- rtl/multiview_pixel_source_mapper_unit.sv -----
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_mode i_coord_u i_coord_v i_coef_slot i_coef_kind i_coef_value
// output    o_valid / i_ready    o_present o_src_index o_local_u o_local_v
// config    psel penable pwrite  paddr pwdata prdata pready (APB, 32-bit)
//
// One item per cycle sustained while the output is not stalled; five register stages, and a map
// item's result is offered from the fifth once it has passed the first four.
// Latency is set by the two-level split multiply and the wide sum in each coordinate lane.
// A coefficient write takes effect as the item leaves the first stage; it yields no result.
// Synchronous reset clears control, configuration and the coefficient table.
// Each stage holds its item while the next cannot accept, so bubbles close up under output stall.
`include "multiview_pixel_source_mapper_unit_defines.svh"

module multiview_pixel_source_mapper_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_mode,
    input  logic signed [mvpsm_pkg::COORD_W-1:0]  i_coord_u,
    input  logic signed [mvpsm_pkg::COORD_W-1:0]  i_coord_v,
    input  logic [mvpsm_pkg::SLOT_W-1:0]          i_coef_slot,
    input  logic [mvpsm_pkg::KIND_W-1:0]          i_coef_kind,
    input  logic signed [mvpsm_pkg::COEF_W-1:0]   i_coef_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_present,
    output logic [mvpsm_pkg::SLOT_W-1:0]          o_src_index,
    output logic [mvpsm_pkg::LOC_W-1:0]           o_local_u,
    output logic [mvpsm_pkg::LOC_W-1:0]           o_local_v,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [mvpsm_pkg::ADDR_W-1:0]          paddr,
    input  logic [mvpsm_pkg::DATA_W-1:0]          pwdata,
    output logic [mvpsm_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready
);
    import mvpsm_pkg::*;

    t_cfg r_cfg;

    logic [2:0] reg_idx;
    logic       cfg_we;

    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic                      r_mode1;
    logic [SLOT_W-1:0]         r_wslot1;
    logic [KIND_W-1:0]         r_wkind1;
    logic [COEF_W-1:0]         r_wdata1;
    logic [SLOT_W-1:0]         r_slot1, r_slot2, r_slot3, r_slot4;
    logic                      r_drop1, r_drop2, r_drop3, r_drop4;
    logic signed [COORD_W-1:0] r_lu1;
    logic signed [COORD_W-1:0] r_v_coord1;

    logic                      r_present;
    logic [SLOT_W-1:0]         r_src_index;
    logic [LOC_W-1:0]          r_local_u;
    logic [LOC_W-1:0]          r_local_v;

    logic [SLOT_W-1:0]         f_sslot;
    logic signed [COORD_W-1:0] f_lu;
    logic                      f_drop;
    t_coef_set                 coef;
    t_pipe_en                  pipe_en;
    logic                      ok_u, ok_v, keep;
    logic [LOC_W-1:0]          loc_u, loc_v;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b0;
            r_cfg.layout_mode    <= LAYOUT_SBS;
            r_cfg.active_tracks  <= CNT_W'(1);
            r_cfg.split_position <= SPLIT_W'(32768);
            r_cfg.slot_order     <= 8'd228;
            r_cfg.present_mask   <= 4'd0;
        end else if (cfg_we) begin
            case (reg_idx)
                REG_ENABLE:  r_cfg.enable         <= pwdata[0];
                REG_LAYOUT:  r_cfg.layout_mode    <= pwdata[1:0];
                REG_TRACKS:  r_cfg.active_tracks  <= pwdata[CNT_W-1:0];
                REG_SPLIT:   r_cfg.split_position <= pwdata[SPLIT_W-1:0];
                REG_ORDER:   r_cfg.slot_order     <= pwdata[7:0];
                REG_PRESENT: r_cfg.present_mask   <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ENABLE:  prdata = DATA_W'(r_cfg.enable);
            REG_LAYOUT:  prdata = DATA_W'(r_cfg.layout_mode);
            REG_TRACKS:  prdata = DATA_W'(r_cfg.active_tracks);
            REG_SPLIT:   prdata = DATA_W'(r_cfg.split_position);
            REG_ORDER:   prdata = DATA_W'(r_cfg.slot_order);
            REG_PRESENT: prdata = DATA_W'(r_cfg.present_mask);
            default:     prdata = '0;
        endcase
    end

    assign rdy5    = !r_v5 || i_ready;
    assign rdy4    = !r_v4 || rdy5;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    assign pipe_en.s2 = rdy2;
    assign pipe_en.s3 = rdy3;
    assign pipe_en.s4 = rdy4;

    mvpsm_front u_front (
        .i_cfg     (r_cfg),
        .i_coord_u (i_coord_u),
        .o_sslot   (f_sslot),
        .o_lu      (f_lu),
        .o_drop    (f_drop)
    );

    mvpsm_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_v1 && r_mode1 == MODE_WRITE && rdy2),
        .i_wslot (r_wslot1),
        .i_wkind (r_wkind1),
        .i_wdata (r_wdata1),
        .i_rslot (r_slot1),
        .o_coef  (coef)
    );

    mvpsm_lane u_lane_u (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_coord (r_lu1),
        .i_off   ($signed(coef.off_x)),
        .i_inv   ($signed(coef.inv_x)),
        .i_view  ($signed(coef.view_x)),
        .o_ok    (ok_u),
        .o_local (loc_u)
    );

    mvpsm_lane u_lane_v (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_coord (r_v_coord1),
        .i_off   ($signed(coef.off_y)),
        .i_inv   ($signed(coef.inv_y)),
        .i_view  ($signed(coef.view_y)),
        .o_ok    (ok_v),
        .o_local (loc_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1 && r_mode1 == MODE_MAP;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    assign keep = !r_drop4 && ok_u && ok_v;

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_mode1    <= i_mode;
            r_wslot1   <= i_coef_slot;
            r_wkind1   <= i_coef_kind;
            r_wdata1   <= i_coef_value;
            r_slot1    <= f_sslot;
            r_drop1    <= f_drop;
            r_lu1      <= f_lu;
            r_v_coord1 <= i_coord_v;
        end
        if (rdy2) begin
            r_slot2 <= r_slot1;
            r_drop2 <= r_drop1;
        end
        if (rdy3) begin
            r_slot3 <= r_slot2;
            r_drop3 <= r_drop2;
        end
        if (rdy4) begin
            r_slot4 <= r_slot3;
            r_drop4 <= r_drop3;
        end
        if (rdy5 && r_v4) begin
            r_present   <= keep;
            r_src_index <= keep ? r_slot4 : '0;
            r_local_u   <= keep ? loc_u : '0;
            r_local_v   <= keep ? loc_v : '0;
        end
    end

    assign o_valid     = r_v5;
    assign o_present   = r_present;
    assign o_src_index = r_src_index;
    assign o_local_u   = r_local_u;
    assign o_local_v   = r_local_v;

    `MVPSM_ASSERT_IMPL(a_absent_zero, i_clk, i_rst_n, o_valid && !o_present, o_src_index == '0 && o_local_u == '0 && o_local_v == '0)
    `MVPSM_ASSERT_IMPL(a_local_range, i_clk, i_rst_n, o_valid && o_present, o_local_u <= LOC_W'(UNIT) && o_local_v <= LOC_W'(UNIT))
    `MVPSM_ASSERT_IMPL(a_present_src, i_clk, i_rst_n, o_valid && o_present, r_cfg.enable && r_cfg.present_mask[o_src_index])
    `MVPSM_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, r_v1 && r_mode1 == MODE_WRITE && rdy2, !r_v2)

endmodule

// ----- bench/tb_multiview_pixel_source_mapper_unit.sv -----
`timescale 1ns / 1ps

module tb_multiview_pixel_source_mapper_unit;
    import mvpsm_pkg::*;

    localparam int HOLD_CYCLES = 120;
    localparam int LAT_PAD     = 12;

    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] coord_u;
        logic signed [COORD_W-1:0] coord_v;
        logic [SLOT_W-1:0]         coef_slot;
        logic [KIND_W-1:0]         coef_kind;
        logic signed [COEF_W-1:0]  coef_value;
    } t_map_item;

    typedef struct packed {
        logic              present;
        logic [SLOT_W-1:0] src_index;
        logic [LOC_W-1:0]  local_u;
        logic [LOC_W-1:0]  local_v;
    } t_map_result;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic                      i_mode = MODE_MAP;
    logic signed [COORD_W-1:0] i_coord_u = '0;
    logic signed [COORD_W-1:0] i_coord_v = '0;
    logic [SLOT_W-1:0]         i_coef_slot = '0;
    logic [KIND_W-1:0]         i_coef_kind = '0;
    logic signed [COEF_W-1:0]  i_coef_value = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_present;
    logic [SLOT_W-1:0]         o_src_index;
    logic [LOC_W-1:0]          o_local_u;
    logic [LOC_W-1:0]          o_local_v;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [ADDR_W-1:0]         paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    t_cfg                     cfg_model;
    logic signed [COEF_W-1:0] coef_model [COEF_SLOTS*COEF_KINDS];
    t_map_result              expected_maps [$];
    t_map_result              exp_res;
    int                       fail_count = 0;
    int                       send_idle_pct = 0;
    int                       recv_stall_pct = 0;
    int                       hold_seq = 0;

    multiview_pixel_source_mapper_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_coord_u    (i_coord_u),
        .i_coord_v    (i_coord_v),
        .i_coef_slot  (i_coef_slot),
        .i_coef_kind  (i_coef_kind),
        .i_coef_value (i_coef_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_present    (o_present),
        .o_src_index  (o_src_index),
        .o_local_u    (o_local_u),
        .o_local_v    (o_local_v),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint tex_coord(input longint c, input longint off,
                                         input longint inv, input longint view);
        longint prod;
        prod = (c - off) * inv;
        return (prod >>> 16) - view;
    endfunction

    function automatic t_map_result map_sample(input logic signed [COORD_W-1:0] u,
                                               input logic signed [COORD_W-1:0] v);
        t_map_result r;
        longint      lu;
        longint      vv;
        longint      cu;
        longint      scaled;
        longint      split;
        longint      tu;
        longint      tv;
        int          count;
        int          dcount;
        int          dslot;
        int          sslot;
        int          base;
        r = '0;
        if (!cfg_model.enable) return r;
        lu = longint'(u);
        vv = longint'(v);
        count = int'(cfg_model.active_tracks);
        if (count < 1) count = 1;
        if (count > MAX_TRACKS) count = MAX_TRACKS;
        dcount = (cfg_model.layout_mode == LAYOUT_SPLIT && count > 1) ? 2 : count;
        dslot = 0;
        if (cfg_model.layout_mode == LAYOUT_SBS && dcount > 1) begin
            cu = lu < 0 ? 0 : (lu > U_CLAMP_HI ? U_CLAMP_HI : lu);
            scaled = cu * dcount;
            dslot = int'(scaled >>> 16);
            if (dslot > dcount - 1) dslot = dcount - 1;
            lu = scaled & 64'hFFFF;
        end else if (cfg_model.layout_mode == LAYOUT_SPLIT && dcount > 1) begin
            split = longint'(cfg_model.split_position);
            if (split < SPLIT_LO) split = SPLIT_LO;
            if (split > SPLIT_HI) split = SPLIT_HI;
            dslot = lu < split ? 0 : 1;
        end
        sslot = int'(cfg_model.slot_order >> (2 * (dslot % 4))) & 3;
        if (sslot > MAX_TRACKS - 1) sslot = MAX_TRACKS - 1;
        if (!cfg_model.present_mask[sslot]) return r;
        base = sslot * COEF_KINDS;
        tu = tex_coord(lu, coef_model[base + KIND_OFF_X], coef_model[base + KIND_INV_X],
                       coef_model[base + KIND_VIEW_X]);
        tv = tex_coord(vv, coef_model[base + KIND_OFF_Y], coef_model[base + KIND_INV_Y],
                       coef_model[base + KIND_VIEW_Y]);
        if (tu < 0 || tu > UNIT || tv < 0 || tv > UNIT) return r;
        r.present = 1'b1;
        r.src_index = SLOT_W'(sslot);
        r.local_u = LOC_W'(tu);
        r.local_v = LOC_W'(tv);
        return r;
    endfunction

    task automatic project_item(input t_map_item it);
        if (it.mode == MODE_WRITE) begin
            if (it.coef_kind < COEF_KINDS)
                coef_model[it.coef_slot * COEF_KINDS + it.coef_kind] = it.coef_value;
        end else begin
            expected_maps.push_back(map_sample(it.coord_u, it.coord_v));
        end
    endtask

    function automatic t_map_item map_at(input int u, input int v);
        t_map_item it;
        it.mode = MODE_MAP;
        it.coord_u = COORD_W'(u);
        it.coord_v = COORD_W'(v);
        it.coef_slot = SLOT_W'($urandom);
        it.coef_kind = KIND_W'($urandom);
        it.coef_value = $urandom;
        return it;
    endfunction

    function automatic t_map_item coef_write(input int slot, input logic [KIND_W-1:0] kind,
                                             input logic [COEF_W-1:0] value);
        t_map_item it;
        it = map_at($urandom, $urandom);
        it.mode = MODE_WRITE;
        it.coef_slot = SLOT_W'(slot);
        it.coef_kind = kind;
        it.coef_value = value;
        return it;
    endfunction

    function automatic t_map_item random_item();
        t_map_item it;
        if ($urandom_range(99) < 25) begin
            it = coef_write($urandom_range(0, 3), KIND_W'($urandom_range(0, 5)), $urandom);
            if ($urandom_range(99) < 5) it.coef_kind = KIND_W'($urandom_range(6, 7));
            if ($urandom_range(99) >= 10) begin
                case (it.coef_kind)
                    KIND_INV_X, KIND_INV_Y: it.coef_value = $urandom_range(32768, 131072);
                    default: it.coef_value = int'($urandom_range(0, 16384)) - 8192;
                endcase
            end
        end else if ($urandom_range(99) < 80) begin
            it = map_at(int'($urandom_range(0, 73728)) - 4096,
                        int'($urandom_range(0, 73728)) - 4096);
        end else begin
            it = map_at($urandom, $urandom);
        end
        return it;
    endfunction

    task automatic send_item(input t_map_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= it.mode;
        i_coord_u <= it.coord_u;
        i_coord_v <= it.coord_v;
        i_coef_slot <= it.coef_slot;
        i_coef_kind <= it.coef_kind;
        i_coef_value <= it.coef_value;
        do @(posedge i_clk); while (!o_ready);
        project_item(it);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_maps.size() > 0) @(posedge i_clk);
        repeat (LAT_PAD) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_ENABLE:  cfg_model.enable = data[0];
            REG_LAYOUT:  cfg_model.layout_mode = data[1:0];
            REG_TRACKS:  cfg_model.active_tracks = data[CNT_W-1:0];
            REG_SPLIT:   cfg_model.split_position = data[SPLIT_W-1:0];
            REG_ORDER:   cfg_model.slot_order = data[7:0];
            REG_PRESENT: cfg_model.present_mask = data[3:0];
            default: ;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input t_cfg c);
        drain();
        write_reg(REG_ENABLE, DATA_W'(c.enable));
        write_reg(REG_LAYOUT, DATA_W'(c.layout_mode));
        write_reg(REG_TRACKS, DATA_W'(c.active_tracks));
        write_reg(REG_SPLIT, DATA_W'(c.split_position));
        write_reg(REG_ORDER, DATA_W'(c.slot_order));
        write_reg(REG_PRESENT, DATA_W'(c.present_mask));
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // receiver: random stalls, plus long hold-offs on request
    initial begin
        int hold_ack;
        hold_ack = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != hold_ack) begin
                hold_ack = hold_seq;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_maps.size() == 0) begin
                $error("result with no item pending: present=%0d src=%0d u=%0d v=%0d",
                       o_present, o_src_index, o_local_u, o_local_v);
                fail_count++;
            end else begin
                exp_res = expected_maps.pop_front();
                if (o_present !== exp_res.present) begin
                    $error("present: expected %0d, got %0d", exp_res.present, o_present);
                    fail_count++;
                end
                if (o_src_index !== exp_res.src_index) begin
                    $error("src_index: expected %0d, got %0d",
                           exp_res.src_index, o_src_index);
                    fail_count++;
                end
                if (o_local_u !== exp_res.local_u) begin
                    $error("local_u: expected %0d, got %0d", exp_res.local_u, o_local_u);
                    fail_count++;
                end
                if (o_local_v !== exp_res.local_v) begin
                    $error("local_v: expected %0d, got %0d", exp_res.local_v, o_local_v);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset_state();
        set_idle(0, 0);
        send_item(map_at(0, 0));
        send_item(map_at(32768, 32768));
        send_item(map_at(-131072, 131071));
        send_item(coef_write(0, KIND_W'(6), 32'h0001_0000));
        send_item(coef_write(3, KIND_W'(7), 32'hFFFF_FFFF));
    endtask

    task automatic test_directed();
        set_config({1'b1, LAYOUT_SBS, 3'd4, 17'd32768, 8'd228, 4'hF});
        send_item(coef_write(0, KIND_INV_X, 32'h0001_0000));
        send_item(coef_write(0, KIND_INV_Y, 32'h0001_0000));
        send_item(map_at(0, 0));
        send_item(map_at(65535, 65535));
        send_item(map_at(-131072, -131072));
        send_item(map_at(131071, 131071));
        send_item(map_at(16384, 32768));
        send_item(map_at(32767, 0));
        send_item(map_at(49152, 65536));
        send_item(map_at(65536, 65537));
        send_item(coef_write(1, KIND_OFF_X, 32'h8000_0000));
        send_item(coef_write(1, KIND_INV_X, 32'h7FFF_FFFF));
        send_item(coef_write(1, KIND_VIEW_X, 32'h7FFF_FFFF));
        send_item(coef_write(1, KIND_INV_Y, 32'h8000_0000));
        send_item(map_at(20000, 0));
        send_item(map_at(30000, -1));
    endtask

    task automatic test_config_sweep();
        t_cfg setting;
        int   k;
        int   n;
        for (k = 0; k < 12; k++) begin
            case (k)
                0: setting = {1'b1, LAYOUT_SBS, 3'd4, 17'd32768, 8'd228, 4'hF};
                1: setting = {1'b1, LAYOUT_SBS, 3'd2, 17'd32768, 8'h1B, 4'hF};
                2: setting = {1'b1, LAYOUT_SBS, 3'd3, 17'd100, 8'($urandom), 4'b1011};
                3: setting = {1'b1, LAYOUT_SPLIT, 3'd2, 17'd0, 8'($urandom), 4'hF};
                4: setting = {1'b1, LAYOUT_SPLIT, 3'd4, 17'd65536, 8'($urandom), 4'hF};
                5: setting = {1'b1, LAYOUT_SPLIT, 3'd7, 17'd7, 8'hFF, 4'hF};
                6: setting = {1'b1, 2'd2, 3'd4, 17'($urandom), 8'($urandom), 4'hF};
                7: setting = {1'b1, 2'd3, 3'd0, 17'($urandom), 8'h00, 4'h0};
                8: setting = {1'b0, LAYOUT_SBS, 3'd4, 17'd32768, 8'd228, 4'hF};
                9: setting = {1'b1, LAYOUT_SPLIT, 3'd1, 17'd65529, 8'($urandom), 4'hF};
                10: setting = {1'b1, LAYOUT_SBS, 3'd4, 17'($urandom), 8'($urandom),
                               4'($urandom)};
                default: setting = {1'b1, 2'($urandom), 3'($urandom),
                                    17'($urandom_range(0, 65536)), 8'($urandom),
                                    4'($urandom)};
            endcase
            set_config(setting);
            case (k % 4)
                0: set_idle(0, 0);
                1: set_idle(70, 0);
                2: set_idle(0, 70);
                default: set_idle(20, 20);
            endcase
            for (n = 0; n < 35; n++) send_item(random_item());
        end
    endtask

    task automatic test_output_backpressure();
        int n;
        set_config({1'b1, LAYOUT_SBS, 3'd4, 17'd32768, 8'd228, 4'hF});
        set_idle(0, 0);
        hold_seq <= hold_seq + 1;
        for (n = 0; n < 40; n++) send_item(random_item());
    endtask

    initial begin
        int i;
        cfg_model = {1'b0, 2'd0, 3'd1, 17'd32768, 8'd228, 4'h0};
        for (i = 0; i < COEF_SLOTS * COEF_KINDS; i++) coef_model[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed();
        test_config_sweep();
        test_output_backpressure();
        drain();
        if (fail_count == 0 && expected_maps.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
